[sv/rgb_conv3x3_filter_macros.svh]
// assertion helpers shared by the filter modules
`ifndef RGB_CONV3X3_FILTER_MACROS_SVH
`define RGB_CONV3X3_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RCF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rgb_conv3x3_filter: property failed");
`define RCF_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("rgb_conv3x3_filter: forbidden condition seen");
`else
`define RCF_ASSERT(label, clk, rst, prop)
`define RCF_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

[sv/rcf_pkg.sv]
package rcf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int CH_W        = 8;
   localparam int COL_W       = 10;
   localparam int ROW_W       = 16;
   localparam int IMG_W_W     = 11;
   localparam int IMG_H_W     = 16;
   localparam int TAPS        = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd768;

   // filter arithmetic: sums are exact multiples of 1/144
   localparam int SUM_W       = 19;
   localparam int DIV_SHIFT   = 4;       // 144 = 16 * 9
   localparam int DIV_X_W     = 12;      // below saturation, sum / 16 fits here
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = DIV_X_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;  // ceil(2^16 / 9)
   localparam logic signed [SUM_W-1:0] SAT_LIMIT = 19'sd36864;  // 256 * 144
   localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KERNEL_BOX     = 2'd0,
      KERNEL_SHARPEN = 2'd1,
      KERNEL_EMBOSS  = 2'd2,
      KERNEL_GAUSS   = 2'd3
   } kernel_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic [CH_W-1:0]  out_red;
      logic [CH_W-1:0]  out_green;
      logic [CH_W-1:0]  out_blue;
      logic             last;
   } rsp_type;

   localparam int PIX_W  = $bits(req_type);
   localparam int LINE_W = 2 * PIX_W;

   typedef req_type [TAPS-1:0] window_type;
   typedef logic [TAPS-1:0][CH_W-1:0] taps_type;

   // what travels beside the lanes for one pixel beat
   typedef struct packed {
      logic             int_valid;
      logic             bord_valid;
      logic [ROW_W-1:0] int_row;
      logic [COL_W-1:0] int_col;
      logic [ROW_W-1:0] bord_row;
      logic [COL_W-1:0] bord_col;
      req_type          bord_pix;
   } meta_type;

endpackage

[sv/rcf_ram.sv]
module rcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[sv/rcf_lane.sv]
module rcf_lane (
   input  logic                      clock,
   input  logic                      en,
   input  rcf_pkg::kernel_type       kernel,
   input  rcf_pkg::taps_type         taps,
   output logic [rcf_pkg::CH_W-1:0]  result
);
   import rcf_pkg::*;

   logic signed [SUM_W-1:0] t [TAPS];
   logic signed [SUM_W-1:0] base;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic [DIV_X_W-1:0]      div_x;
   logic [PROD_W-1:0]       prod;
   logic [CH_W-1:0]         result_in;
   logic [CH_W-1:0]         result_ff;

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         t[i] = SUM_W'(taps[i]);
      end
   end

   // each kernel is a small add tree times a common factor of its coefficients
   always_comb begin
      case (kernel)
         KERNEL_BOX: begin
            base   = t[0] + t[1] + t[2] + t[3] + t[4] + t[5] + t[6] + t[7] + t[8];
            sum_in = base <<< 4;
         end
         KERNEL_SHARPEN: begin
            base   = (t[4] <<< 2) + (t[4] <<< 1) - t[1] - t[3] - t[5] - t[7];
            sum_in = (base <<< 6) + (base <<< 3);
         end
         KERNEL_EMBOSS: begin
            base   = t[4] + t[5] + t[7] + (t[8] <<< 1) - (t[0] <<< 1) - t[1] - t[3];
            sum_in = (base <<< 7) + (base <<< 4);
         end
         KERNEL_GAUSS: begin
            base   = t[0] + t[2] + t[6] + t[8] + (t[4] <<< 2)
                   + ((t[1] + t[3] + t[5] + t[7]) <<< 1);
            sum_in = (base <<< 3) + base;
         end
         default: begin
            base   = '0;
            sum_in = '0;
         end
      endcase
   end

   // floor(sum / 144) as floor(floor(sum / 16) / 9), reciprocal exact below saturation
   always_comb begin
      div_x = sum_ff[DIV_SHIFT+DIV_X_W-1:DIV_SHIFT];
      prod  = PROD_W'(div_x) * PROD_W'(RECIP_9);
      if (sum_ff <= 0) begin
         result_in = '0;
      end else if (sum_ff >= SAT_LIMIT) begin
         result_in = CH_MAX;
      end else begin
         result_in = prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff    <= sum_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[sv/rcf_merge.sv]
`include "rgb_conv3x3_filter_macros.svh"

module rcf_merge (
   input  logic              clock,
   input  logic              reset,
   input  rcf_pkg::meta_type meta,
   input  rcf_pkg::req_type  res_pix,
   output logic              en,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcf_pkg::rsp_type  rsp_data
);
   import rcf_pkg::*;

   meta_type            meta_d1_ff;
   meta_type            meta_d2_ff;
   rsp_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic [QCNT_W-1:0]   n_push;
   logic                pop;
   rsp_type             int_item;
   rsp_type             bord_item;

   // room for two entries (both results of one beat) keeps the whole pipe moving
   assign en        = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      int_item.out_row   = meta_d2_ff.int_row;
      int_item.out_col   = meta_d2_ff.int_col;
      int_item.out_red   = res_pix.red;
      int_item.out_green = res_pix.green;
      int_item.out_blue  = res_pix.blue;
      int_item.last      = !meta_d2_ff.bord_valid;

      bord_item.out_row   = meta_d2_ff.bord_row;
      bord_item.out_col   = meta_d2_ff.bord_col;
      bord_item.out_red   = meta_d2_ff.bord_pix.red;
      bord_item.out_green = meta_d2_ff.bord_pix.green;
      bord_item.out_blue  = meta_d2_ff.bord_pix.blue;
      bord_item.last      = 1'b1;

      n_push = '0;
      if (en) begin
         n_push = QCNT_W'(meta_d2_ff.int_valid) + QCNT_W'(meta_d2_ff.bord_valid);
      end
      wr_ptr_in = wr_ptr_ff + QPTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + n_push - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_d1_ff <= '0;
         meta_d2_ff <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (en) begin
            meta_d1_ff <= meta;
            meta_d2_ff <= meta_d1_ff;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // filtered pixel goes first, border copy behind it
   always_ff @(posedge clock) begin
      if (en) begin
         if (meta_d2_ff.int_valid) begin
            queue_ff[wr_ptr_ff] <= int_item;
            if (meta_d2_ff.bord_valid) begin
               queue_ff[wr_ptr_ff + QPTR_W'(1)] <= bord_item;
            end
         end else if (meta_d2_ff.bord_valid) begin
            queue_ff[wr_ptr_ff] <= bord_item;
         end
      end
   end

   `RCF_ASSERT_NEVER(a_queue_overflow, clock, reset, count_ff > QCNT_W'(QUEUE_DEPTH))
   `RCF_ASSERT(a_pair_follows, clock, reset, rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)

endmodule

[sv/rgb_conv3x3_filter.sv]
// a result reaches rsp through stage 1, stage 2, the lane registers and the queue after the
// beat that completes it is taken (a border pixel on its own beat, interior pixel (r,c) on
// the beat of pixel (r+1,c+1)); throughput: one pixel per cycle; a two-result beat gives
// two responses, and the four-entry queue holds off req_ready while more than two wait
// reset (synchronous, active high) clears counters, window and queue and loads the
// default registers; the line memory is not cleared and needs no clearing pass
`include "rgb_conv3x3_filter_macros.svh"

module rgb_conv3x3_filter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rcf_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rcf_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [rcf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rcf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rcf_pkg::*;

   logic [1:0]          kernel_ff;
   logic [IMG_W_W-1:0]  width_ff;
   logic [IMG_H_W-1:0]  height_ff;
   logic [IMG_W_W-1:0]  w_eff;
   logic [IMG_H_W-1:0]  h_eff;

   logic [COL_W-1:0]    col_ff;
   logic [COL_W-1:0]    col_in;
   logic [ROW_W-1:0]    row_ff;
   logic [ROW_W-1:0]    row_in;
   logic [IMG_W_W-1:0]  col_next;
   logic [ROW_W:0]      row_next;
   logic                is_border;
   logic                is_int;

   logic                en;
   logic                accept;

   logic                s1_valid_ff;
   req_type             s1_pix_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_int_ff;
   logic                s1_bord_ff;
   logic                fwd_sel_ff;
   logic [LINE_W-1:0]   fwd_data_ff;
   logic [LINE_W-1:0]   line_rd;
   logic [LINE_W-1:0]   line_eff;
   req_type             s1_top;
   req_type             s1_mid;

   req_type             window_ff [6];
   window_type          s2_win_ff;
   meta_type            s2_meta_ff;
   meta_type            s2_meta_in;

   taps_type            red_taps;
   taps_type            green_taps;
   taps_type            blue_taps;
   req_type             res_pix;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= KERNEL_BOX;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KERNEL: kernel_ff <= csr_wdata[1:0];
            CSR_WIDTH:  width_ff  <= csr_wdata[IMG_W_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[IMG_H_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = IMG_W_W'(1);
      end else if (width_ff > IMG_W_W'(MAX_WIDTH)) begin
         w_eff = IMG_W_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? IMG_H_W'(1) : height_ff;
   end

   // raster position of the incoming pixel
   assign req_ready = en;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_next  = {1'b0, col_ff} + IMG_W_W'(1);
      row_next  = {1'b0, row_ff} + (ROW_W+1)'(1);
      is_border = (row_ff == '0) || (row_ff >= h_eff - IMG_H_W'(1)) ||
                  (col_ff == '0) || ({1'b0, col_ff} >= w_eff - IMG_W_W'(1));
      is_int    = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (col_next >= w_eff) begin
            col_in = '0;
            row_in = (row_next >= {1'b0, h_eff}) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line memory read lands, column written back as {mid, pixel}
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_data;
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
         s1_int_ff   <= is_int;
         s1_bord_ff  <= is_border;
         // same column written on this edge: take the new entry, not the stale read
         fwd_sel_ff  <= s1_valid_ff && (s1_col_ff == col_ff);
         fwd_data_ff <= {s1_mid, s1_pix_ff};
      end
   end

   rcf_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (en && s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_mid, s1_pix_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   always_comb begin
      line_eff = fwd_sel_ff ? fwd_data_ff : line_rd;
      if (s1_row_ff == '0) begin
         s1_top = '0;
         s1_mid = '0;
      end else begin
         s1_top = line_eff[LINE_W-1:PIX_W];
         s1_mid = line_eff[PIX_W-1:0];
      end
   end

   // stage 2: 3x3 window and beat description
   always_comb begin
      s2_meta_in.int_valid  = s1_valid_ff && s1_int_ff;
      s2_meta_in.bord_valid = s1_valid_ff && s1_bord_ff;
      s2_meta_in.int_row    = s1_row_ff - ROW_W'(1);
      s2_meta_in.int_col    = s1_col_ff - COL_W'(1);
      s2_meta_in.bord_row   = s1_row_ff;
      s2_meta_in.bord_col   = s1_col_ff;
      s2_meta_in.bord_pix   = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_meta_ff <= '0;
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= '0;
         end
      end else if (en) begin
         s2_meta_ff <= s2_meta_in;
         if (s1_valid_ff) begin
            window_ff[0] <= window_ff[3];
            window_ff[1] <= window_ff[4];
            window_ff[2] <= window_ff[5];
            window_ff[3] <= s1_top;
            window_ff[4] <= s1_mid;
            window_ff[5] <= s1_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_win_ff[0] <= window_ff[0];
         s2_win_ff[1] <= window_ff[3];
         s2_win_ff[2] <= s1_top;
         s2_win_ff[3] <= window_ff[1];
         s2_win_ff[4] <= window_ff[4];
         s2_win_ff[5] <= s1_mid;
         s2_win_ff[6] <= window_ff[2];
         s2_win_ff[7] <= window_ff[5];
         s2_win_ff[8] <= s1_pix_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         red_taps[i]   = s2_win_ff[i].red;
         green_taps[i] = s2_win_ff[i].green;
         blue_taps[i]  = s2_win_ff[i].blue;
      end
   end

   // one lane per color channel
   rcf_lane u_lane_red (
      .clock  (clock),
      .en     (en),
      .kernel (kernel_type'(kernel_ff)),
      .taps   (red_taps),
      .result (res_pix.red)
   );

   rcf_lane u_lane_green (
      .clock  (clock),
      .en     (en),
      .kernel (kernel_type'(kernel_ff)),
      .taps   (green_taps),
      .result (res_pix.green)
   );

   rcf_lane u_lane_blue (
      .clock  (clock),
      .en     (en),
      .kernel (kernel_type'(kernel_ff)),
      .taps   (blue_taps),
      .result (res_pix.blue)
   );

   rcf_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .meta      (s2_meta_ff),
      .res_pix   (res_pix),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `RCF_ASSERT(a_counters_hold, clock, reset, !(req_valid && req_ready) |=> $stable(col_ff) && $stable(row_ff))
   `RCF_ASSERT(a_beat_enters, clock, reset, req_valid && req_ready |=> s1_valid_ff)

endmodule
